[rtl/nds_pkg.sv]
// Package for the nearest date search block: beat structs, codes, controller states,
// controller/datapath command and status structs, and the month offset table.
// No dependencies.
`default_nettype none

package nds_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int DAY_W       = 21;
	localparam int OFF_W       = 11;

	localparam logic [1:0] ACT_LOAD  = 2'd0;
	localparam logic [1:0] ACT_CLEAR = 2'd1;
	localparam logic [1:0] ACT_QUERY = 2'd2;

	typedef struct packed {
		logic [1:0]  action;
		logic [4:0]  day;
		logic [3:0]  month_num;
		logic [11:0] year_num;
	} req_t;

	typedef struct packed {
		logic             found;
		logic [7:0]       best_index;
		logic [DAY_W-1:0] distance;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV1,
		ST_CONV2,
		ST_SCAN,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic capture;
		logic conv1;
		logic conv2;
		logic write_entry;
		logic clear_count;
		logic scan_start;
		logic scan_issue;
		logic rsp_load;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] action;
		logic       issue_done;
		logic       pipe_empty;
		logic       rsp_free;
	} dp_status_t;

	// days before the month; month 0 counts as January, 13..15 as December
	function automatic logic [8:0] days_before(input logic [3:0] mon);
		logic [8:0] d;
		case (mon)
			4'd0, 4'd1: d = 9'd0;
			4'd2:       d = 9'd31;
			4'd3:       d = 9'd59;
			4'd4:       d = 9'd90;
			4'd5:       d = 9'd120;
			4'd6:       d = 9'd151;
			4'd7:       d = 9'd181;
			4'd8:       d = 9'd212;
			4'd9:       d = 9'd243;
			4'd10:      d = 9'd273;
			4'd11:      d = 9'd304;
			default:    d = 9'd334;
		endcase
		return d;
	endfunction

endpackage

`default_nettype wire

[rtl/nds_ctrl.sv]
// Controller for the nearest date search block: sequences capture, date
// conversion, table update and the table scan. Depends on nds_pkg.
`default_nettype none

module nds_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 req_valid,
	output logic                req_stall,
	input  nds_pkg::dp_status_t status,
	output nds_pkg::dp_cmd_t    cmd
);
	import nds_pkg::*;

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) state_nxt = ST_CONV1;
			end
			ST_CONV1: state_nxt = ST_CONV2;
			ST_CONV2: begin
				if (status.action == ACT_QUERY) state_nxt = ST_SCAN;
				else state_nxt = ST_IDLE;
			end
			ST_SCAN: begin
				if (status.issue_done) state_nxt = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (status.pipe_empty && status.rsp_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				req_stall   = 1'b0;
				cmd.capture = req_valid;
			end
			ST_CONV1: cmd.conv1 = 1'b1;
			ST_CONV2: begin
				cmd.conv2       = 1'b1;
				cmd.write_entry = (status.action == ACT_LOAD);
				cmd.clear_count = (status.action == ACT_CLEAR);
				cmd.scan_start  = (status.action == ACT_QUERY);
			end
			ST_SCAN: cmd.scan_issue = !status.issue_done;
			ST_DRAIN: cmd.rsp_load = status.pipe_empty && status.rsp_free;
			default: req_stall = 1'b1;
		endcase
	end

endmodule

`default_nettype wire

[rtl/nds_dpath.sv]
// Datapath for the nearest date search block: day count conversion, entry
// table memory, scan pipeline with best tracking, response register. Depends on nds_pkg.
`default_nettype none

module nds_dpath (
	input  wire                 clk,
	input  wire                 arst_n,
	input  nds_pkg::req_t       req_data,
	input  nds_pkg::dp_cmd_t    cmd,
	output nds_pkg::dp_status_t status,
	output logic                rsp_valid,
	input  wire                 rsp_stall,
	output nds_pkg::rsp_t       rsp_data
);
	import nds_pkg::*;

	req_t             item_q;
	logic [DAY_W-1:0] base_q;
	logic [OFF_W-1:0] off_q;
	logic [DAY_W-1:0] key_q;
	logic [DAY_W-1:0] key_sum;

	logic [DAY_W-1:0] entry_mem [TABLE_DEPTH];
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] rd_ptr_q;

	logic [DAY_W-1:0] rd_data_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             vld_s1;
	logic [DAY_W-1:0] dist_s2;
	logic [IDX_W-1:0] idx_s2;
	logic             vld_s2;

	logic             best_have_q;
	logic [DAY_W-1:0] best_dist_q;
	logic [IDX_W-1:0] best_idx_q;

	logic             rsp_valid_q;
	rsp_t             rsp_q;

	logic             full;
	logic             leap_adj;
	logic             better;

	assign full     = (count_q == CNT_W'(TABLE_DEPTH));
	assign leap_adj = (item_q.year_num[1:0] == 2'b00) && (item_q.month_num > 4'd2);
	assign better   = !best_have_q || (dist_s2 < best_dist_q);
	assign key_sum  = base_q + DAY_W'(off_q);

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) item_q <= req_data;
		if (cmd.conv1) begin
			base_q <= DAY_W'(DAY_W'(item_q.year_num) * DAY_W'(365))
				+ DAY_W'((13'(item_q.year_num) + 13'd3) >> 2);
			off_q  <= OFF_W'(days_before(item_q.month_num)) + OFF_W'(leap_adj)
				+ OFF_W'(item_q.day);
		end
		if (cmd.conv2) key_q <= key_sum;
		if (cmd.scan_issue) idx_s1 <= rd_ptr_q[IDX_W-1:0];
		dist_s2 <= (rd_data_s1 > key_q) ? (rd_data_s1 - key_q) : (key_q - rd_data_s1);
		idx_s2  <= idx_s1;
		if (vld_s2 && better) begin
			best_dist_q <= dist_s2;
			best_idx_q  <= idx_s2;
		end
		if (cmd.rsp_load) begin
			rsp_q.found      <= best_have_q;
			rsp_q.best_index <= best_have_q ? 8'(best_idx_q) : 8'd0;
			rsp_q.distance   <= best_have_q ? best_dist_q : '0;
		end
	end

	// entry table
	always_ff @(posedge clk) begin
		if (cmd.write_entry && !full) entry_mem[count_q[IDX_W-1:0]] <= key_sum;
		if (cmd.scan_issue) rd_data_s1 <= entry_mem[rd_ptr_q[IDX_W-1:0]];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rd_ptr_q    <= '0;
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			best_have_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.clear_count) count_q <= '0;
			else if (cmd.write_entry && !full) count_q <= count_q + CNT_W'(1);

			if (cmd.scan_start) rd_ptr_q <= '0;
			else if (cmd.scan_issue) rd_ptr_q <= rd_ptr_q + CNT_W'(1);

			vld_s1 <= cmd.scan_issue;
			vld_s2 <= vld_s1;

			if (cmd.scan_start) best_have_q <= 1'b0;
			else if (vld_s2) best_have_q <= 1'b1;

			if (cmd.rsp_load) rsp_valid_q <= 1'b1;
			else if (!rsp_stall) rsp_valid_q <= 1'b0;
		end
	end

	assign status.action     = item_q.action;
	assign status.issue_done = (rd_ptr_q == count_q);
	assign status.pipe_empty = !vld_s1 && !vld_s2;
	assign status.rsp_free   = !rsp_valid_q || !rsp_stall;

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

endmodule

`default_nettype wire

[rtl/nearest_date_search.sv]
// Top level of the nearest date search block: controller plus datapath.
// Depends on nds_pkg, nds_ctrl, nds_dpath.
//
//   channel  valid      stall      beat
//   request  req_valid  req_stall  req_data (action, day, month_num, year_num)
//   response rsp_valid  rsp_stall  rsp_data (found, best_index, distance)
//
// Load, clear and unused actions pass through capture and two conversion steps.
// A query then scans the table; the scan reads one table entry
// per cycle from the entry memory, plus a two-stage compare pipeline.
// Reset empties the table; entries themselves are not cleared.
// The response register holds a finished beat under rsp_stall while the next
// request is taken; a query completes only once that register is free.
`default_nettype none

module nearest_date_search (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            req_valid,
	output logic           req_stall,
	input  nds_pkg::req_t  req_data,
	output logic           rsp_valid,
	input  wire            rsp_stall,
	output nds_pkg::rsp_t  rsp_data
);
	import nds_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	nds_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.status    (status),
		.cmd       (cmd)
	);

	nds_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_data  (req_data),
		.cmd       (cmd),
		.status    (status),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data)
	);

endmodule

`default_nettype wire

[rtl/nds_checker.sv]
// Port-level checks for the nearest date search block, bound to the top level.
// Depends on nds_pkg.
`default_nettype none

module nds_checker (
	input wire           clk,
	input wire           arst_n,
	input wire           req_valid,
	input wire           req_stall,
	input nds_pkg::req_t req_data,
	input wire           rsp_valid,
	input wire           rsp_stall,
	input nds_pkg::rsp_t rsp_data
);
	import nds_pkg::*;

	// stalled request beat holds
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_stall |=> req_valid && $stable(req_data))
		else $error("request beat changed under stall");

	// stalled response beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
		else $error("response beat changed under stall");

	// an empty table answers with zero index and distance
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_data.found |-> rsp_data.best_index == 8'd0
			&& rsp_data.distance == '0)
		else $error("empty-table response carries nonzero fields");

	// a taken request keeps the block busy for the next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken back to back");

	// a response appears only at the end of a busy period
	a_rsp_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_stall))
		else $error("response raised while idle");

endmodule

bind nearest_date_search nds_checker u_nds_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req_data  (req_data),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp_data  (rsp_data)
);

`default_nettype wire
